/* rtl/bmhq_pkg.sv */
// Shared definitions for the binary min-heap priority queue.
// Holds sizes, the entry and port-bundle structs, status codes and sequencer states.
// No dependencies.
package bmhq_pkg;

  // Heap sizing; slots 1..CAPACITY hold entries, slot 0 is never used.
  localparam int CAPACITY  = 63;
  localparam int KEY_BITS  = 16;
  localparam int TAG_BITS  = 16;
  localparam int SLOTS     = CAPACITY + 1;
  localparam int ADDR_BITS = $clog2(SLOTS);
  localparam int CNT_BITS  = ADDR_BITS;

  // Stream word layouts, padded to whole bytes.
  localparam int IN_FIELD_BITS  = KEY_BITS + TAG_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 1 + KEY_BITS + TAG_BITS + CNT_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_LOAD,
    S_DN_CHK,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_DONE
  } state_t;

  // Memory port request from the sequencer.
  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    entry_t               wdata;
    logic [ADDR_BITS-1:0] raddr;
  } mem_req_t;

  // Finished operation summary handed to the output stage.
  typedef struct packed {
    status_t             status;
    logic [CNT_BITS-1:0] count;
  } result_t;

endpackage

/* rtl/bmhq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the heap slot store; no package dependencies.
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bmhq_ctrl.sv */
// Sift sequencer: runs insert (sift-up) and remove (sift-down) one level at a time,
// sharing one key comparator and the single RAM read port. Uses bmhq_pkg.
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  op_t      in_op,
  input  entry_t   in_entry,
  input  entry_t   rdata,
  output mem_req_t mem_req,
  output logic     res_valid,
  input  logic     res_take,
  output result_t  res
);

  state_t               state, state_next;
  logic [CNT_BITS-1:0]  count;
  logic [ADDR_BITS-1:0] ptr;
  entry_t               cur;
  entry_t               lchild;
  status_t              stat;

  logic [ADDR_BITS:0]   left_idx, right_idx, count_ext;
  logic                 has_left, has_right;
  logic                 take_left;
  entry_t               best;
  logic [ADDR_BITS-1:0] best_idx;
  logic [KEY_BITS-1:0]  cmp_a, cmp_b;
  logic                 cmp_le;

  // Child positions of the current slot.
  assign left_idx  = {ptr, 1'b0};
  assign right_idx = left_idx + 1'b1;
  assign count_ext = {1'b0, count};
  assign has_left  = (left_idx <= count_ext);
  assign has_right = (right_idx <= count_ext);

  // Smaller child; the left one wins a tie.
  assign take_left = (rdata.key >= lchild.key);
  assign best      = take_left ? lchild : rdata;
  assign best_idx  = take_left ? left_idx[ADDR_BITS-1:0] : right_idx[ADDR_BITS-1:0];

  // The shared comparator: a <= b.
  always_comb begin
    cmp_a = cur.key;
    cmp_b = best.key;
    case (state)
      S_UP_CMP: begin
        cmp_a = rdata.key;
        cmp_b = cur.key;
      end
      S_DN_LEFT: begin
        cmp_a = cur.key;
        cmp_b = rdata.key;
      end
      default: begin
        cmp_a = cur.key;
        cmp_b = best.key;
      end
    endcase
  end
  assign cmp_le = (cmp_a <= cmp_b);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.status = stat;
  assign res.count  = count;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_INSERT) begin
            state_next = (count == CNT_BITS'(CAPACITY)) ? S_DONE : S_UP_CHK;
          end else begin
            state_next = (count == '0) ? S_DONE : S_DN_LAST;
          end
        end
      end
      S_UP_CHK:   state_next = (ptr == ADDR_BITS'(1)) ? S_DONE : S_UP_CMP;
      S_UP_CMP:   state_next = cmp_le ? S_DONE : S_UP_CHK;
      S_DN_LAST:  state_next = S_DN_LOAD;
      S_DN_LOAD:  state_next = (count == '0) ? S_DONE : S_DN_CHK;
      S_DN_CHK:   state_next = has_left ? S_DN_LEFT : S_DONE;
      S_DN_LEFT: begin
        if (has_right) begin
          state_next = S_DN_RIGHT;
        end else begin
          state_next = cmp_le ? S_DONE : S_DN_CHK;
        end
      end
      S_DN_RIGHT: state_next = cmp_le ? S_DONE : S_DN_CHK;
      S_DONE:     state_next = res_take ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory port drive.
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = ptr;
    mem_req.wdata = cur;
    mem_req.raddr = ptr;
    case (state)
      S_UP_CHK: begin
        // At the root the entry lands at once; otherwise fetch the parent.
        mem_req.we    = (ptr == ADDR_BITS'(1));
        mem_req.raddr = ptr >> 1;
      end
      S_UP_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = cmp_le ? cur : rdata;
      end
      S_DN_LAST: begin
        mem_req.raddr = count;
      end
      S_DN_CHK: begin
        mem_req.we    = !has_left;
        mem_req.raddr = left_idx[ADDR_BITS-1:0];
      end
      S_DN_LEFT: begin
        mem_req.we    = !has_right;
        mem_req.wdata = cmp_le ? cur : rdata;
        mem_req.raddr = right_idx[ADDR_BITS-1:0];
      end
      S_DN_RIGHT: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = cmp_le ? cur : best;
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        if (in_op == OP_INSERT && count != CNT_BITS'(CAPACITY)) begin
          count <= count + 1'b1;
        end
      end
      if (state == S_DN_LAST) begin
        count <= count - 1'b1;
      end
    end
  end

  // Sift datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cur <= in_entry;
          ptr <= ADDR_BITS'(count + 1'b1);
          if (in_op == OP_INSERT) begin
            stat <= (count == CNT_BITS'(CAPACITY)) ? ST_FULL : ST_DONE;
          end else begin
            stat <= (count == '0) ? ST_EMPTY : ST_DONE;
          end
        end
      end
      S_UP_CMP: begin
        if (!cmp_le) begin
          ptr <= ptr >> 1;
        end
      end
      S_DN_LOAD: begin
        cur <= rdata;
        ptr <= ADDR_BITS'(1);
      end
      S_DN_LEFT: begin
        lchild <= rdata;
        if (!has_right && !cmp_le) begin
          ptr <= left_idx[ADDR_BITS-1:0];
        end
      end
      S_DN_RIGHT: begin
        if (!cmp_le) begin
          ptr <= best_idx;
        end
      end
      default: begin
        ptr <= ptr;
      end
    endcase
  end

endmodule

/* rtl/binary_min_heap_queue.sv */
// Top level of the binary min-heap priority queue: stream ports, heap RAM,
// root copy and output register. Uses bmhq_pkg, bmhq_ram and bmhq_ctrl.
//
//   Channel  Direction  Handshake          Contents
//   s_*      in         s_tvalid/s_tready  one operation word (insert or remove)
//   m_*      out        m_tvalid/m_tready  one result word per operation
//
// An insert climbs toward the root one level at a time, and a remove walks down
// one level at a time while entries remain. The pace is set by the single RAM
// read port, read once per parent or child visited.
// Reset clears the entry count and the control state; heap contents are not cleared.
// A stalled output holds the sequencer in its final state; s_tready stays low until
// the result word has moved into the output register.
module binary_min_heap_queue
  import bmhq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // entry_key, entry_tag
  input  logic                     s_tuser,   // operation
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,   // root_valid, root_key, root_tag, entry_count
  output logic [1:0]               m_tuser    // status
);

  mem_req_t             mem_req;
  entry_t               rdata_raw;
  entry_t               in_entry;
  op_t                  in_op;
  logic                 res_valid;
  logic                 res_take;
  result_t              res;
  entry_t               root;
  status_t              out_status;
  logic                 out_root_valid;
  entry_t               out_root;
  logic [CNT_BITS-1:0]  out_count;

  // Unpack the input word.
  assign in_entry.key = s_tdata[KEY_BITS-1:0];
  assign in_entry.tag = s_tdata[KEY_BITS +: TAG_BITS];
  assign in_op        = op_t'(s_tuser);

  bmhq_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata_raw)
  );

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (in_op),
    .in_entry  (in_entry),
    .rdata     (rdata_raw),
    .mem_req   (mem_req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Keep a copy of slot 1 so the minimum is known without an extra read.
  always_ff @(posedge clk) begin
    if (mem_req.we && mem_req.waddr == ADDR_BITS'(1)) begin
      root <= mem_req.wdata;
    end
  end

  assign res_take = res_valid && (!m_tvalid || m_tready);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_status     <= res.status;
      out_count      <= res.count;
      out_root_valid <= (res.count != '0);
      out_root       <= (res.count != '0) ? root : '0;
    end
  end

  // Pack the result word.
  always_comb begin
    m_tdata = '0;
    m_tdata[0]                                  = out_root_valid;
    m_tdata[1 +: KEY_BITS]                      = out_root.key;
    m_tdata[1 + KEY_BITS +: TAG_BITS]           = out_root.tag;
    m_tdata[1 + KEY_BITS + TAG_BITS +: CNT_BITS] = out_count;
  end
  assign m_tuser = out_status;

  // A refused insert means the heap really was full.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_FULL) |-> (out_count == CNT_BITS'(CAPACITY)))
    else $error("full status with count below capacity");

  // A refused remove leaves an empty heap with a cleared root.
  a_empty_root: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_EMPTY) |-> (out_count == '0 && !out_root_valid))
    else $error("empty status with entries held");

  // The root flag tracks the count.
  a_root_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_root_valid == (out_count != '0)))
    else $error("root_valid disagrees with entry_count");

  // No new operation is taken while a result is still inside the sequencer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !s_tready)
    else $error("input accepted with a result pending");

endmodule

/* tb/binary_min_heap_queue_tb.sv */
// Self-checking testbench for the binary min-heap priority queue.
// Drives insert and remove words, predicts every result word with its own heap model
// and compares field by field; depends on bmhq_pkg and binary_min_heap_queue.
module binary_min_heap_queue_tb
  import bmhq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 40;
  localparam int IDLE_PCT    = 11;

  // One operation word as presented on the input stream.
  typedef struct {
    op_t                 op;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } heap_op_t;

  // Result word fields, highest bit first in the packed order below.
  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    logic [TAG_BITS-1:0] tag;
    logic [KEY_BITS-1:0] key;
    logic                valid;
  } root_word_t;

  typedef struct {
    status_t    status;
    root_word_t root;
  } heap_outcome_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;
  logic                     s_tuser = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic [1:0]               m_tuser;

  heap_op_t      pending_ops[$];
  heap_outcome_t expected_roots[$];
  entry_t        model_heap[SLOTS];
  int            model_count = 0;
  int            total_ops = 0;
  int            accepted_ops = 0;
  int            mismatches = 0;
  int            stall_cycles = 0;
  logic          calm;

  binary_min_heap_queue uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // No random idling on either side during this stretch of the run.
  assign calm = (accepted_ops >= 300) && (accepted_ops < 450);

  // Swap two model slots.
  function automatic void swap_slots(input int a, input int b);
    entry_t t;
    t = model_heap[a];
    model_heap[a] = model_heap[b];
    model_heap[b] = t;
  endfunction

  // Apply one operation to the model heap and return the result word it yields.
  function automatic heap_outcome_t apply_heap_op(input heap_op_t item);
    heap_outcome_t res;
    int            pos;
    int            left;
    int            right;
    int            pick;
    bit            settled;
    res.status = ST_DONE;
    if (item.op == OP_INSERT) begin
      if (model_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        model_count++;
        model_heap[model_count].key = item.key;
        model_heap[model_count].tag = item.tag;
        // Sift up while strictly smaller than the parent; equal keys stay put.
        pos = model_count;
        settled = 1'b0;
        while (pos > 1 && !settled) begin
          if (model_heap[pos].key >= model_heap[pos / 2].key) begin
            settled = 1'b1;
          end else begin
            swap_slots(pos, pos / 2);
            pos = pos / 2;
          end
        end
      end
    end else begin
      if (model_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        model_heap[1] = model_heap[model_count];
        model_count--;
        // Sift down; a right child past the count is ignored, ties go left.
        pos = 1;
        settled = 1'b0;
        while (2 * pos <= model_count && !settled) begin
          left = 2 * pos;
          right = left + 1;
          pick = left;
          if (right <= model_count) begin
            if (model_heap[pos].key <= model_heap[left].key &&
                model_heap[pos].key <= model_heap[right].key)
              settled = 1'b1;
            else if (model_heap[right].key < model_heap[left].key)
              pick = right;
          end else if (model_heap[pos].key <= model_heap[left].key) begin
            settled = 1'b1;
          end
          if (!settled) begin
            swap_slots(pos, pick);
            pos = pick;
          end
        end
      end
    end
    res.root.count = CNT_BITS'(model_count);
    res.root.valid = (model_count > 0);
    res.root.key   = (model_count > 0) ? model_heap[1].key : '0;
    res.root.tag   = (model_count > 0) ? model_heap[1].tag : '0;
    return res;
  endfunction

  task automatic queue_op(input op_t op, input logic [KEY_BITS-1:0] key,
                          input logic [TAG_BITS-1:0] tag);
    heap_op_t item;
    item.op  = op;
    item.key = key;
    item.tag = tag;
    pending_ops.push_back(item);
    total_ops++;
  endtask

  // Keys lean toward a narrow range and the extremes so that ties are common.
  function automatic logic [KEY_BITS-1:0] draw_key();
    logic [KEY_BITS-1:0] k;
    case ($urandom_range(3))
      0: begin
        k = KEY_BITS'($urandom_range(7));
      end
      1: begin
        k = $urandom_range(1) ? '1 : '0;
      end
      default: begin
        k = KEY_BITS'($urandom);
      end
    endcase
    return k;
  endfunction

  // A run of random words with the given share of inserts.
  task automatic queue_phase(input int n, input int insert_pct);
    for (int i = 0; i < n; i++)
      queue_op(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE,
               draw_key(), TAG_BITS'($urandom));
  endtask

  // Input driver: present the next word once the previous one has gone.
  always @(posedge clk) begin : drive
    heap_op_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (!s_tvalid || s_tready) begin
        if (pending_ops.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          item = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {item.tag, item.key};
          s_tuser  <= item.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word, then predict for each accepted input word.
  always @(posedge clk) begin : watch
    heap_op_t      item;
    heap_outcome_t want;
    root_word_t    got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[OUT_FIELD_BITS-1:0];
        if (expected_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word status=%0d data=%h", $realtime,
                     m_tuser, m_tdata);
        end else begin
          want = expected_roots.pop_front();
          if (status_t'(m_tuser) !== want.status || got.valid !== want.root.valid ||
              got.key !== want.root.key || got.tag !== want.root.tag ||
              got.count !== want.root.count ||
              m_tdata[OUT_DATA_BITS-1:OUT_FIELD_BITS] !== '0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: expected status=%0d valid=%0d key=%h tag=%h count=%0d",
                       $realtime, want.status, want.root.valid, want.root.key,
                       want.root.tag, want.root.count);
              $display("%0t: got status=%0d valid=%0d key=%h tag=%h count=%0d pad=%b",
                       $realtime, m_tuser, got.valid, got.key, got.tag, got.count,
                       m_tdata[OUT_DATA_BITS-1:OUT_FIELD_BITS]);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        item.op  = op_t'(s_tuser);
        item.key = s_tdata[KEY_BITS-1:0];
        item.tag = s_tdata[KEY_BITS+TAG_BITS-1:KEY_BITS];
        expected_roots.push_back(apply_heap_op(item));
        accepted_ops <= accepted_ops + 1;
      end
    end
  end

  // Watchdog: give up when neither side moves a word for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    // Directed opening: empty remove, key and tag extremes, equal keys.
    queue_op(OP_REMOVE, '1, '1);
    queue_op(OP_INSERT, '1, '0);
    queue_op(OP_INSERT, '0, '1);
    queue_op(OP_INSERT, '0, 16'h1234);
    queue_op(OP_INSERT, 16'h8000, 16'haaaa);
    queue_op(OP_INSERT, 16'h0001, 16'h5555);
    queue_op(OP_REMOVE, '0, '0);
    queue_op(OP_REMOVE, 16'h5a5a, 16'ha5a5);
    queue_op(OP_REMOVE, '0, '0);
    queue_op(OP_REMOVE, '0, '0);
    queue_op(OP_REMOVE, '0, '0);
    queue_op(OP_REMOVE, '0, '0);
    // Two equal children under a larger moved entry: the left one must win.
    queue_op(OP_INSERT, 16'd1, 16'h0100);
    queue_op(OP_INSERT, 16'd5, 16'h0a0a);
    queue_op(OP_INSERT, 16'd5, 16'h0b0b);
    queue_op(OP_INSERT, 16'd9, 16'h0c0c);
    queue_op(OP_REMOVE, '0, '0);
    queue_op(OP_REMOVE, '0, '0);
    queue_op(OP_REMOVE, '0, '0);
    queue_op(OP_REMOVE, '0, '0);
    queue_op(OP_REMOVE, '0, '0);

    // Random part: fill past full, drain past empty, and mixed traffic.
    queue_phase(100, 90);
    queue_phase(100, 10);
    queue_phase(150, 55);
    queue_phase(100, 90);
    queue_phase(100, 10);
    queue_phase(200, 50);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (accepted_ops < total_ops)
      @(posedge clk);
    while (expected_roots.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && expected_roots.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
